// ===== sv/b64e_pkg.sv =====
`timescale 1ns / 1ps

package b64e_pkg;

    localparam logic [6:0] CharPlus  = 7'd43;
    localparam logic [6:0] CharSlash = 7'd47;
    localparam logic [6:0] CharPad   = 7'd61;

    // Position of the next byte within its three-byte group
    typedef enum logic [1:0] {
        PH_FIRST  = 2'd0,
        PH_SECOND = 2'd1,
        PH_THIRD  = 2'd2
    } b64e_phase_t;

    // Characters produced by one byte, handed from front to back
    typedef struct packed {
        logic [3:0][6:0] chars;
        logic [1:0]      last_idx;
        logic            msg_end;
    } b64e_job_t;

    function automatic logic [6:0] sextet_char(input logic [5:0] v);
        logic [6:0] c;
        if (v < 6'd26)
        begin
            c = 7'd65 + {1'b0, v};
        end
        else if (v < 6'd52)
        begin
            c = 7'd71 + {1'b0, v};
        end
        else if (v < 6'd62)
        begin
            c = {1'b0, v} - 7'd4;
        end
        else if (v == 6'd62)
        begin
            c = CharPlus;
        end
        else
        begin
            c = CharSlash;
        end
        return c;
    endfunction

endpackage

// ===== sv/b64e_stream_if.sv =====
`timescale 1ns / 1ps

interface b64e_msg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_message;

    modport source (output valid, output data_byte, output end_of_message, input ready);
    modport sink (input valid, input data_byte, input end_of_message, output ready);
endinterface

interface b64e_code_if;
    logic       valid;
    logic       ready;
    logic [6:0] code_char;
    logic       final_char;

    modport source (output valid, output code_char, output final_char, input ready);
    modport sink (input valid, input code_char, input final_char, output ready);
endinterface

// ===== sv/b64e_front.sv =====
`timescale 1ns / 1ps

module b64e_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  logic [7:0]         data_byte,
    input  logic               end_of_message,
    output b64e_pkg::b64e_job_t job
);

    b64e_pkg::b64e_phase_t phase_reg;
    b64e_pkg::b64e_phase_t phase_next;
    logic [3:0]            left_reg;
    logic [3:0]            left_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= b64e_pkg::PH_FIRST;
            left_reg  <= 4'd0;
        end
        else if (push)
        begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
        end
    end

    always_comb
    begin
        job          = '0;
        job.msg_end  = end_of_message;
        phase_next   = b64e_pkg::PH_FIRST;
        left_next    = 4'd0;
        case (phase_reg)
            b64e_pkg::PH_SECOND:
            begin
                job.chars[0] = b64e_pkg::sextet_char({left_reg[1:0], data_byte[7:4]});
                if (end_of_message)
                begin
                    job.chars[1] = b64e_pkg::sextet_char({data_byte[3:0], 2'b00});
                    job.chars[2] = b64e_pkg::CharPad;
                    job.last_idx = 2'd2;
                end
                else
                begin
                    job.last_idx = 2'd0;
                    phase_next   = b64e_pkg::PH_THIRD;
                    left_next    = data_byte[3:0];
                end
            end
            b64e_pkg::PH_THIRD:
            begin
                job.chars[0] = b64e_pkg::sextet_char({left_reg, data_byte[7:6]});
                job.chars[1] = b64e_pkg::sextet_char(data_byte[5:0]);
                job.last_idx = 2'd1;
            end
            default:
            begin
                // unused phase code behaves as the first byte of a group
                job.chars[0] = b64e_pkg::sextet_char(data_byte[7:2]);
                if (end_of_message)
                begin
                    job.chars[1] = b64e_pkg::sextet_char({data_byte[1:0], 4'b0000});
                    job.chars[2] = b64e_pkg::CharPad;
                    job.chars[3] = b64e_pkg::CharPad;
                    job.last_idx = 2'd3;
                end
                else
                begin
                    job.last_idx = 2'd0;
                    phase_next   = b64e_pkg::PH_SECOND;
                    left_next    = {2'b00, data_byte[1:0]};
                end
            end
        endcase
    end

endmodule

// ===== sv/b64e_queue.sv =====
`timescale 1ns / 1ps

module b64e_queue
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  b64e_pkg::b64e_job_t push_job,
    output logic                full,
    input  logic                pop,
    output logic                empty,
    output b64e_pkg::b64e_job_t head
);

    localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CntW = $clog2(QUEUE_DEPTH + 1);

    b64e_pkg::b64e_job_t slots_reg [QUEUE_DEPTH];
    logic [PtrW-1:0]     wr_ptr_reg;
    logic [PtrW-1:0]     wr_ptr_next;
    logic [PtrW-1:0]     rd_ptr_reg;
    logic [PtrW-1:0]     rd_ptr_next;
    logic [CntW-1:0]     count_reg;
    logic [CntW-1:0]     count_next;

    assign full  = (count_reg == CntW'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ===== sv/b64e_back.sv =====
`timescale 1ns / 1ps

module b64e_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                empty,
    input  b64e_pkg::b64e_job_t head,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [6:0]          code_char,
    output logic                final_char
);

    logic       valid_reg;
    logic       valid_next;
    logic [6:0] char_reg;
    logic [6:0] char_next;
    logic       final_reg;
    logic       final_next;
    logic [1:0] idx_reg;
    logic [1:0] idx_next;
    logic       load;
    logic       at_last;

    assign load    = !valid_reg || out_ready;
    assign at_last = (idx_reg == head.last_idx);

    always_comb
    begin
        valid_next = valid_reg;
        char_next  = char_reg;
        final_next = final_reg;
        idx_next   = idx_reg;
        pop        = 1'b0;
        if (load)
        begin
            valid_next = !empty;
            if (!empty)
            begin
                char_next  = head.chars[idx_reg];
                final_next = head.msg_end && at_last;
                if (at_last)
                begin
                    pop      = 1'b1;
                    idx_next = 2'd0;
                end
                else
                begin
                    idx_next = idx_reg + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg  <= char_next;
        final_reg <= final_next;
    end

    assign out_valid  = valid_reg;
    assign code_char  = char_reg;
    assign final_char = final_reg;

endmodule

// ===== sv/base64_stream_encoder.sv =====
`timescale 1ns / 1ps

// Base64 stream encoder, standard alphabet with '=' padding. Bytes enter on msg, one per
// transaction, and the encoded characters leave on code, one per transaction, with
// final_char set on the character that closes the message (the byte carrying
// end_of_message). The front end takes a byte in every cycle while its job queue has room
// (QUEUE_DEPTH entries) and turns it into one to four characters; the back end drains those
// through a single output register at one character per cycle while code is ready. Each
// character passes through the job queue and then the output register. Sustained
// throughput is set by that output register, which sends four characters for every three
// bytes in mid-message; a final byte yields two to four characters by its group position.
module base64_stream_encoder
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    b64e_msg_if.sink    msg,
    b64e_code_if.source code
);

    b64e_pkg::b64e_job_t front_job;
    b64e_pkg::b64e_job_t head_job;
    logic                q_full;
    logic                q_empty;
    logic                q_push;
    logic                q_pop;

    assign msg.ready = !q_full;
    assign q_push    = msg.valid && !q_full;

    b64e_front u_front
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (q_push),
        .data_byte      (msg.data_byte),
        .end_of_message (msg.end_of_message),
        .job            (front_job)
    );

    b64e_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (front_job),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .head     (head_job)
    );

    b64e_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .empty      (q_empty),
        .head       (head_job),
        .pop        (q_pop),
        .out_valid  (code.valid),
        .out_ready  (code.ready),
        .code_char  (code.code_char),
        .final_char (code.final_char)
    );

endmodule

// ===== sv/b64e_checker.sv =====
`timescale 1ns / 1ps

module b64e_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       code_valid,
    input logic       code_ready,
    input logic [6:0] code_char,
    input logic       final_char
);

    logic       code_xfer;
    logic [1:0] pos_reg;

    assign code_xfer = code_valid && code_ready;

    // position of the next character within its four-character block
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= 2'd0;
        end
        else if (code_xfer)
        begin
            pos_reg <= final_char ? 2'd0 : pos_reg + 2'd1;
        end
    end

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        code_valid && !code_ready |=> code_valid && $stable(code_char) && $stable(final_char))
        else $error("output changed while stalled");

    a_alphabet: assert property (@(posedge clk) disable iff (!rst_n)
        code_valid |-> (code_char >= 7'd65 && code_char <= 7'd90)
                    || (code_char >= 7'd97 && code_char <= 7'd122)
                    || (code_char >= 7'd48 && code_char <= 7'd57)
                    || code_char == b64e_pkg::CharPlus || code_char == b64e_pkg::CharSlash
                    || code_char == b64e_pkg::CharPad)
        else $error("character outside the Base64 alphabet");

    a_final_block: assert property (@(posedge clk) disable iff (!rst_n)
        code_xfer && final_char |-> pos_reg == 2'd3)
        else $error("message length not a multiple of four characters");

    a_pad_place: assert property (@(posedge clk) disable iff (!rst_n)
        code_xfer && code_char == b64e_pkg::CharPad |-> pos_reg == 2'd2 || pos_reg == 2'd3)
        else $error("padding in the wrong position");

    a_reset_idle: assert property (@(posedge clk)
        $past(!rst_n) |-> !code_valid)
        else $error("output valid right after reset");

endmodule

bind base64_stream_encoder b64e_checker u_b64e_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .code_valid (code.valid),
    .code_ready (code.ready),
    .code_char  (code.code_char),
    .final_char (code.final_char)
);

// ===== tb/base64_stream_encoder_tb.sv =====
`timescale 1ns / 1ps

module base64_stream_encoder_tb;

    localparam int StallLimit  = 2000;
    localparam int DrainCycles = 16;
    localparam int ReportLimit = 10;

    typedef struct packed {
        logic [6:0] code_char;
        logic       final_char;
    } code_item_t;

    logic clk;
    logic rst_n;

    b64e_msg_if  msg_if();
    b64e_code_if code_if();

    base64_stream_encoder DUT
    (
        .clk   (clk),
        .rst_n (rst_n),
        .msg   (msg_if),
        .code  (code_if)
    );

    string                 alphabet =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    b64e_pkg::b64e_phase_t enc_phase;
    logic [3:0]            enc_left;
    code_item_t            expected_chars[$];
    int                    send_idle_pct;
    int                    recv_idle_pct;
    int                    error_count = 0;
    int                    stall_cycles;

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic logic [6:0] sextet_to_char(input logic [5:0] v);
        byte c;
        c = alphabet[v];
        return c[6:0];
    endfunction

    task automatic note_failure(input string what);
        error_count++;
        if (error_count <= ReportLimit)
        begin
            $display("%t: %s", $realtime, what);
        end
    endtask

    // Expected characters for one accepted byte
    task automatic encode_byte(input logic [7:0] b, input logic eom);
        logic [6:0] chars [4];
        int         n;
        n = 0;
        case (enc_phase)
            b64e_pkg::PH_SECOND:
            begin
                chars[0]  = sextet_to_char({enc_left[1:0], b[7:4]});
                enc_left  = b[3:0];
                enc_phase = b64e_pkg::PH_THIRD;
                n         = 1;
            end
            b64e_pkg::PH_THIRD:
            begin
                chars[0]  = sextet_to_char({enc_left, b[7:6]});
                chars[1]  = sextet_to_char(b[5:0]);
                enc_left  = 4'd0;
                enc_phase = b64e_pkg::PH_FIRST;
                n         = 2;
            end
            default:
            begin
                chars[0]  = sextet_to_char(b[7:2]);
                enc_left  = {2'b00, b[1:0]};
                enc_phase = b64e_pkg::PH_SECOND;
                n         = 1;
            end
        endcase
        if (eom)
        begin
            if (enc_phase == b64e_pkg::PH_SECOND)
            begin
                chars[n]     = sextet_to_char({enc_left[1:0], 4'b0000});
                chars[n + 1] = b64e_pkg::CharPad;
                chars[n + 2] = b64e_pkg::CharPad;
                n            = n + 3;
            end
            else if (enc_phase == b64e_pkg::PH_THIRD)
            begin
                chars[n]     = sextet_to_char({enc_left, 2'b00});
                chars[n + 1] = b64e_pkg::CharPad;
                n            = n + 2;
            end
            enc_phase = b64e_pkg::PH_FIRST;
            enc_left  = 4'd0;
        end
        for (int i = 0; i < n; i++)
        begin
            expected_chars.push_back('{code_char: chars[i], final_char: eom && (i == n - 1)});
        end
    endtask

    // Returns in the time step of the accepting edge with valid still high
    task automatic send_byte(input logic [7:0] b, input logic eom);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            msg_if.valid <= 1'b0;
            @(posedge clk);
        end
        msg_if.valid          <= 1'b1;
        msg_if.data_byte      <= b;
        msg_if.end_of_message <= eom;
        @(posedge clk);
        while (!msg_if.ready)
        begin
            @(posedge clk);
        end
        encode_byte(b, eom);
    endtask

    task automatic send_message(input logic [7:0] bytes_q[$]);
        for (int i = 0; i < bytes_q.size(); i++)
        begin
            send_byte(bytes_q[i], i == bytes_q.size() - 1);
        end
    endtask

    // Single-byte messages: flush of two leftover bits and two pad characters
    task automatic test_single_byte_messages();
        send_message('{8'h00});
        send_message('{8'hFF});
    endtask

    // Messages ending in the first or second byte of a group, incl. across a group boundary
    task automatic test_padding_cases();
        send_message('{8'hFF, 8'h00});
        send_message('{8'h00, 8'hFF});
        send_message('{8'h4D, 8'h61, 8'h6E, 8'hA5});
        send_message('{8'h5A, 8'hC3, 8'h0F, 8'hF0, 8'h81});
    endtask

    // First and last alphabet entries, '+' and '/', on a full group
    task automatic test_alphabet_edges();
        send_message('{8'h00, 8'h00, 8'h00});
        send_message('{8'hFB, 8'hEF, 8'hBE});
        send_message('{8'hFF, 8'hFF, 8'hFF});
    endtask

    task automatic test_random_messages(input int n_bytes);
        int         sent;
        int         len;
        logic [7:0] bytes_q[$];
        sent = 0;
        while (sent < n_bytes)
        begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
            bytes_q.delete();
            repeat (len)
            begin
                bytes_q.push_back(8'($urandom_range(0, 255)));
            end
            send_message(bytes_q);
            sent += len;
        end
    endtask

    always @(posedge clk)
    begin : check_output
        code_item_t want;
        code_item_t got;
        if (rst_n && code_if.valid && code_if.ready)
        begin
            got = '{code_char: code_if.code_char, final_char: code_if.final_char};
            if (expected_chars.size() == 0)
            begin
                note_failure($sformatf("unexpected transaction: char %0d final %0b",
                                       got.code_char, got.final_char));
            end
            else
            begin
                want = expected_chars.pop_front();
                if (got.code_char != want.code_char)
                begin
                    note_failure($sformatf("code_char: expected %0d, got %0d",
                                           want.code_char, got.code_char));
                end
                if (got.final_char != want.final_char)
                begin
                    note_failure($sformatf("final_char: expected %0b, got %0b (char %0d)",
                                           want.final_char, got.final_char, got.code_char));
                end
            end
        end
        code_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (msg_if.valid && msg_if.ready) || (code_if.valid && code_if.ready))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= StallLimit)
        begin
            $display("CHECK FAILED");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial
    begin
        rst_n                 = 1'b0;
        msg_if.valid          = 1'b0;
        msg_if.data_byte      = 8'h00;
        msg_if.end_of_message = 1'b0;
        enc_phase             = b64e_pkg::PH_FIRST;
        enc_left              = 4'd0;
        send_idle_pct         = 32;
        recv_idle_pct         = 47;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        test_single_byte_messages();
        test_padding_cases();
        test_alphabet_edges();
        test_random_messages(25);

        send_idle_pct = 47;
        recv_idle_pct = 32;
        test_random_messages(25);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_messages(25);

        msg_if.valid <= 1'b0;
        while (expected_chars.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DrainCycles) @(posedge clk);
        if (error_count == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== base64_stream_encoder.f =====
sv/b64e_pkg.sv
sv/b64e_stream_if.sv
sv/b64e_front.sv
sv/b64e_queue.sv
sv/b64e_back.sv
sv/base64_stream_encoder.sv
sv/b64e_checker.sv
tb/base64_stream_encoder_tb.sv
